>>> rtl/core/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg: shared types and constants of the length-prefixed deframer
// Field widths, register indexes, result kinds and the queue item and
// session table entry layouts.
// ----------------------------------------------------------------------------
package lpd_pkg;

	// Field widths
	localparam int SESSION_W = 6;
	localparam int BYTE_W    = 8;
	localparam int QUEUE_W   = 4;
	localparam int KIND_W    = 2;
	localparam int TC_W      = 5;
	localparam int MAXLEN_W  = 24;
	localparam int LEN_W     = 32;
	localparam int HDR_CNT_W = 2;
	localparam int CFG_IDX_W = 4;

	// Framing constants
	localparam int HEADER_BYTES = 4;
	localparam int SESSIONS_DEF = 64;
	localparam int TC_MAX       = 16;
	localparam int QUEUE_DEPTH  = 2;

	// Register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_THREAD_COUNT    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BODY_LENGTH = 4'd1;
	localparam logic [TC_W-1:0]      TC_RESET            = 5'd4;
	localparam logic [MAXLEN_W-1:0]  MAXLEN_RESET        = 24'd1024000;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_BODY  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

	// Item handed from the front part to the back part
	typedef struct packed {
		logic [SESSION_W-1:0] session;
		logic [BYTE_W-1:0]    data;
		logic [QUEUE_W-1:0]   queue;
	} lpd_item_t;

	// Per-session table entry
	typedef struct packed {
		logic                 in_body;
		logic [HDR_CNT_W-1:0] hdr_seen;
		logic [LEN_W-1:0]     len_rem;
	} lpd_entry_t;

endpackage

>>> rtl/core/lpd_front.sv
// ----------------------------------------------------------------------------
// lpd_front: input side of the deframer
// Accepts an item, drops sessions beyond the table and works out the
// worker queue (session mod thread count) one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpd_front #(
	parameter int SESSIONS = lpd_pkg::SESSIONS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [lpd_pkg::SESSION_W-1:0]  session_id,
	input  logic [lpd_pkg::BYTE_W-1:0]     data_byte,
	input  logic [lpd_pkg::TC_W-1:0]       thread_count,
	output logic                           push_valid,
	input  logic                           push_ready,
	output lpd_pkg::lpd_item_t             push_item
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} front_state_t;

	localparam int CNT_W = $clog2(lpd_pkg::SESSION_W);

	front_state_t                   state_q;
	logic [lpd_pkg::SESSION_W-1:0]  sess_q;
	logic [lpd_pkg::BYTE_W-1:0]     data_q;
	logic [lpd_pkg::TC_W-1:0]       rem_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [lpd_pkg::TC_W-1:0]       divisor;
	logic [lpd_pkg::TC_W-1:0]       rem_sh;
	logic [lpd_pkg::TC_W-1:0]       rem_nx;
	logic                           in_range;

	// Effective thread count: zero acts as one, above sixteen as sixteen
	always_comb begin
		if (thread_count == '0)
			divisor = lpd_pkg::TC_W'(1);
		else if (thread_count > lpd_pkg::TC_W'(lpd_pkg::TC_MAX))
			divisor = lpd_pkg::TC_W'(lpd_pkg::TC_MAX);
		else
			divisor = thread_count;
	end

	// One restoring remainder step
	always_comb begin
		rem_sh = {rem_q[lpd_pkg::TC_W-2:0], sess_q[cnt_q]};
		rem_nx = (rem_sh >= divisor) ? (rem_sh - divisor) : rem_sh;
	end

	assign in_range   = 32'(session_id) < SESSIONS;
	assign in_ready   = (state_q == F_IDLE);
	assign push_valid = (state_q == F_PUSH);
	assign push_item  = '{session: sess_q, data: data_q,
	                      queue: rem_q[lpd_pkg::QUEUE_W-1:0]};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid && in_range)
						state_q <= F_DIV;
				end
				F_DIV: begin
					if (cnt_q == '0)
						state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (push_ready)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Item and remainder datapath
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			sess_q <= session_id;
			data_q <= data_byte;
			rem_q  <= '0;
			cnt_q  <= CNT_W'(lpd_pkg::SESSION_W - 1);
		end else if (state_q == F_DIV) begin
			rem_q <= rem_nx;
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

>>> rtl/core/lpd_fifo.sv
// ----------------------------------------------------------------------------
// lpd_fifo: short item queue between front and back
// Lets either side stall without holding up the other.
// ----------------------------------------------------------------------------
module lpd_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  lpd_pkg::lpd_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output lpd_pkg::lpd_item_t pop_item
);

	localparam int DEPTH = lpd_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lpd_pkg::lpd_item_t slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_item;
	end

endmodule

>>> rtl/core/lpd_back.sv
// ----------------------------------------------------------------------------
// lpd_back: session table and result generation
// Reads the session entry, advances header or body phase, writes it back,
// loads the output register for results and clears the table after reset.
// ----------------------------------------------------------------------------
module lpd_back #(
	parameter int SESSIONS = lpd_pkg::SESSIONS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pop_valid,
	output logic                             pop_ready,
	input  lpd_pkg::lpd_item_t               pop_item,
	input  logic [lpd_pkg::MAXLEN_W-1:0]     max_body_length,
	output logic                             clearing,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [lpd_pkg::SESSION_W-1:0]    out_session,
	output logic [lpd_pkg::QUEUE_W-1:0]      queue_index,
	output logic [lpd_pkg::BYTE_W-1:0]       out_byte,
	output logic [lpd_pkg::KIND_W-1:0]       result_kind,
	output logic                             message_end
);

	typedef enum logic [2:0] {
		B_CLEAR = 3'b001,
		B_IDLE  = 3'b010,
		B_EXEC  = 3'b100
	} back_state_t;

	localparam int SES_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

	back_state_t             state_q;
	logic [SES_W-1:0]        clr_cnt_q;
	lpd_pkg::lpd_item_t      item_q;
	lpd_pkg::lpd_entry_t     table_mem [SESSIONS];
	lpd_pkg::lpd_entry_t     rd_q;

	logic                    slot_free;
	logic                    exec_fire;
	logic                    wr_en;
	logic [SES_W-1:0]        wr_addr;
	lpd_pkg::lpd_entry_t     wr_data;
	lpd_pkg::lpd_entry_t     nx_entry;
	logic                    emit;
	logic [lpd_pkg::KIND_W-1:0] emit_kind;
	logic                    emit_end;
	logic [lpd_pkg::LEN_W-1:0]  rem_dec;
	logic [lpd_pkg::LEN_W-1:0]  hdr_len;

	assign clearing  = (state_q == B_CLEAR);
	assign pop_ready = (state_q == B_IDLE);
	assign slot_free = !out_valid || out_ready;
	assign exec_fire = (state_q == B_EXEC) && slot_free;

	// Next entry and result for the current item
	always_comb begin
		rem_dec   = (rd_q.len_rem != '0) ? rd_q.len_rem - lpd_pkg::LEN_W'(1) : '0;
		hdr_len   = {rd_q.len_rem[lpd_pkg::LEN_W-lpd_pkg::BYTE_W-1:0], item_q.data};
		nx_entry  = rd_q;
		emit      = 1'b0;
		emit_kind = lpd_pkg::KIND_BODY;
		emit_end  = 1'b0;
		if (rd_q.in_body) begin
			// body byte: count down, mark the last one
			nx_entry.len_rem = rem_dec;
			nx_entry.in_body = (rem_dec != '0);
			emit             = 1'b1;
			emit_end         = (rem_dec == '0);
		end else if (rd_q.hdr_seen != lpd_pkg::HDR_CNT_W'(lpd_pkg::HEADER_BYTES - 1)) begin
			// early header byte: shift into the length
			nx_entry.len_rem  = hdr_len;
			nx_entry.hdr_seen = rd_q.hdr_seen + lpd_pkg::HDR_CNT_W'(1);
		end else begin
			// last header byte: check the length
			nx_entry.hdr_seen = '0;
			if (hdr_len > lpd_pkg::LEN_W'(max_body_length)) begin
				nx_entry.len_rem = '0;
				emit             = 1'b1;
				emit_kind        = lpd_pkg::KIND_ERROR;
				emit_end         = 1'b1;
			end else if (hdr_len == '0) begin
				nx_entry.len_rem = '0;
				emit             = 1'b1;
				emit_kind        = lpd_pkg::KIND_EMPTY;
				emit_end         = 1'b1;
			end else begin
				nx_entry.len_rem = hdr_len;
				nx_entry.in_body = 1'b1;
			end
		end
	end

	// Table write port: clearing pass or write-back
	always_comb begin
		wr_en   = clearing || exec_fire;
		wr_addr = clearing ? clr_cnt_q : SES_W'(item_q.session);
		wr_data = clearing ? '0 : nx_entry;
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			clr_cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				B_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + SES_W'(1);
					if (clr_cnt_q == SES_W'(SESSIONS - 1))
						state_q <= B_IDLE;
				end
				B_IDLE: begin
					if (pop_valid)
						state_q <= B_EXEC;
				end
				B_EXEC: begin
					if (slot_free)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
			if (exec_fire && emit)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	// Item capture and output payload
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && pop_valid)
			item_q <= pop_item;
		if (exec_fire && emit) begin
			out_session <= item_q.session;
			queue_index <= item_q.queue;
			out_byte    <= (emit_kind == lpd_pkg::KIND_BODY) ? item_q.data : '0;
			result_kind <= emit_kind;
			message_end <= emit_end;
		end
	end

	// Session table memory
	always_ff @(posedge clk) begin
		if (wr_en)
			table_mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && pop_valid)
			rd_q <= table_mem[SES_W'(pop_item.session)];
	end

endmodule

>>> rtl/core/length_prefixed_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_deframer: per-session 32-bit big-endian length deframer
// Splits a tagged byte stream into messages with a four-byte length header.
// ----------------------------------------------------------------------------
// Each item is accepted, gets its queue index remainder one bit per cycle
// of the six-bit session number and is handed to the two-entry queue; the
// front takes no new item until it has handed on the last. The table read,
// update and write-back behind the queue overlap the next item's remainder.
// A result is held in an output register; while it waits the table stage
// holds its item, and the block keeps taking items until the two-entry
// queue and the remainder stage are full. After reset the session table is
// cleared one entry a cycle, during which in_ready stays low; configuration
// writes are taken at any time and cfg_ready is always high.
module length_prefixed_deframer #(
	parameter int SESSIONS = lpd_pkg::SESSIONS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [lpd_pkg::SESSION_W-1:0]    session_id,
	input  logic [lpd_pkg::BYTE_W-1:0]       data_byte,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [lpd_pkg::SESSION_W-1:0]    out_session,
	output logic [lpd_pkg::QUEUE_W-1:0]      queue_index,
	output logic [lpd_pkg::BYTE_W-1:0]       out_byte,
	output logic [lpd_pkg::KIND_W-1:0]       result_kind,
	output logic                             message_end,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lpd_pkg::MAXLEN_W-1:0]     cfg_data
);

	logic [lpd_pkg::TC_W-1:0]     thread_count_q;
	logic [lpd_pkg::MAXLEN_W-1:0] max_body_length_q;
	logic                         clearing;
	logic                         front_ready;
	logic                         push_valid;
	logic                         push_ready;
	lpd_pkg::lpd_item_t           push_item;
	logic                         pop_valid;
	logic                         pop_ready;
	lpd_pkg::lpd_item_t           pop_item;

	assign cfg_ready = 1'b1;
	assign in_ready  = front_ready && !clearing;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thread_count_q    <= lpd_pkg::TC_RESET;
			max_body_length_q <= lpd_pkg::MAXLEN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lpd_pkg::REG_THREAD_COUNT:
					thread_count_q <= cfg_data[lpd_pkg::TC_W-1:0];
				lpd_pkg::REG_MAX_BODY_LENGTH:
					max_body_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lpd_front #(
		.SESSIONS (SESSIONS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid && !clearing),
		.in_ready     (front_ready),
		.session_id   (session_id),
		.data_byte    (data_byte),
		.thread_count (thread_count_q),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_item    (push_item)
	);

	lpd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	lpd_back #(
		.SESSIONS (SESSIONS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.pop_valid       (pop_valid),
		.pop_ready       (pop_ready),
		.pop_item        (pop_item),
		.max_body_length (max_body_length_q),
		.clearing        (clearing),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_session     (out_session),
		.queue_index     (queue_index),
		.out_byte        (out_byte),
		.result_kind     (result_kind),
		.message_end     (message_end)
	);

endmodule

>>> rtl/core/lpd_checker.sv
// ----------------------------------------------------------------------------
// lpd_checker: port-level checks of the deframer
// Output handshake rules and result field consistency.
// ----------------------------------------------------------------------------
module lpd_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [lpd_pkg::SESSION_W-1:0] out_session,
	input  logic [lpd_pkg::QUEUE_W-1:0]   queue_index,
	input  logic [lpd_pkg::BYTE_W-1:0]    out_byte,
	input  logic [lpd_pkg::KIND_W-1:0]    result_kind,
	input  logic                          message_end
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_session) && $stable(out_byte)
			&& $stable(result_kind) && $stable(message_end) && $stable(queue_index))
		else $error("result payload changed while stalled");

	// Empty-message and error results close the message and carry no byte
	a_event_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != lpd_pkg::KIND_BODY |-> message_end && out_byte == '0)
		else $error("event result with byte or open message");

	// A remainder never exceeds the session number
	a_queue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 6'(queue_index) <= out_session)
		else $error("queue index above session number");

endmodule

bind length_prefixed_deframer lpd_checker u_lpd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.out_session (out_session),
	.queue_index (queue_index),
	.out_byte    (out_byte),
	.result_kind (result_kind),
	.message_end (message_end)
);
